// ===== src/jukes_cantor_distance_assert.svh =====
// Assertion macros shared by the distance correction RTL.
`ifndef JUKES_CANTOR_DISTANCE_ASSERT_SVH
`define JUKES_CANTOR_DISTANCE_ASSERT_SVH
`ifndef SYNTHESIS
`define JCD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("jcd assertion failed");
`define JCD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("jcd reset assertion failed");
`else
`define JCD_ASSERT(lbl, prop)
`define JCD_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== src/jcd_pkg.sv =====
// Types and constants of the Jukes-Cantor distance correction pipeline.
package jcd_pkg;

  localparam int COUNT_BITS = 20;
  localparam int FRAC_BITS  = 16;
  localparam int DIST_BITS  = 22;
  localparam int LOG_FRAC   = 28;
  localparam int NB         = COUNT_BITS + 5;   // width of 19 * sites
  localparam int KB         = $clog2(NB);
  localparam int MANT_BITS  = 32;
  localparam int LOGB       = KB + LOG_FRAC;
  localparam int P_BITS     = LOGB + LOG_FRAC - 20;
  localparam int X_BITS     = P_BITS + 3;
  localparam int CHUNK      = 11;
  localparam int NCHUNK     = X_BITS / CHUNK;
  localparam int SHIFT      = 36 - FRAC_BITS;
  localparam int RECIP5     = 13108;            // ceil(2^16 / 5)

  localparam logic [LOG_FRAC-1:0] LN2_Q28 = LOG_FRAC'(28'hB17217F);

  typedef enum logic {
    ALPHA_DNA     = 1'b0,
    ALPHA_PROTEIN = 1'b1
  } alpha_e;

  typedef struct packed {
    logic [COUNT_BITS-1:0] mismatch_count_first;
    logic [COUNT_BITS-1:0] mismatch_count_second;
    logic [COUNT_BITS-1:0] compared_sites;
  } in_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic                 saturated;
  } out_t;

  typedef struct packed {
    logic   zero;
    logic   sat;
    alpha_e mode;
  } ctl_t;

endpackage

// ===== src/jukes_cantor_distance.sv =====
// Jukes-Cantor distance correction: a 38-stage pipeline that accepts one count triple per
// cycle unless stalled and returns one result per item; most of the depth is the 28 squaring
// stages of the two fixed-point log2 units. A stall on the output freezes the whole pipeline.
`include "jukes_cantor_distance_assert.svh"
module jukes_cantor_distance (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  jcd_pkg::in_t     in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output jcd_pkg::out_t    out_data_o
);

  localparam int LF = jcd_pkg::LOG_FRAC;
  localparam int NC = jcd_pkg::NCHUNK;
  localparam int CW = jcd_pkg::CHUNK;
  localparam int XB = jcd_pkg::X_BITS;

  jcd_pkg::alpha_e mode_q;
  logic            en;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jcd_pkg::ALPHA_DNA;
    end else if (cfg_we_i) begin
      mode_q <= jcd_pkg::alpha_e'(cfg_wdata_i);
    end
  end

  logic out_valid_q;
  jcd_pkg::out_t out_q;
  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Stage 1: integer forms of N, A and R plus the special cases.
  logic [jcd_pkg::COUNT_BITS:0] total;
  logic [jcd_pkg::NB-1:0]       n_d;
  logic [jcd_pkg::NB:0]         aa;
  jcd_pkg::ctl_t                c1_d;

  always_comb begin
    total = {1'b0, in_data_i.mismatch_count_first} +
            {1'b0, in_data_i.mismatch_count_second};
    if (mode_q == jcd_pkg::ALPHA_PROTEIN) begin
      n_d = jcd_pkg::NB'({5'b0, in_data_i.compared_sites} * jcd_pkg::NB'(19));
      aa  = (jcd_pkg::NB+1)'({5'b0, total} * (jcd_pkg::NB+1)'(20));
    end else begin
      n_d = jcd_pkg::NB'({5'b0, in_data_i.compared_sites} * jcd_pkg::NB'(3));
      aa  = (jcd_pkg::NB+1)'({total, 2'b00});
    end
    c1_d.zero = (in_data_i.compared_sites == '0);
    c1_d.sat  = !c1_d.zero && (aa >= {1'b0, n_d});
    c1_d.mode = mode_q;
  end

  logic                   v1_q;
  logic [jcd_pkg::NB-1:0] n1_q, r1_q;
  jcd_pkg::ctl_t          c1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q <= n_d;
      r1_q <= n_d - aa[jcd_pkg::NB-1:0];
      c1_q <= c1_d;
    end
  end

  // Stage 2: normalize both operands to a Q1.31 mantissa.
  function automatic logic [jcd_pkg::KB-1:0] top_bit(input logic [jcd_pkg::NB-1:0] x);
    logic [jcd_pkg::KB-1:0] k;
    k = '0;
    for (int i = 0; i < jcd_pkg::NB; i++) begin
      if (x[i]) k = jcd_pkg::KB'(i);
    end
    return k;
  endfunction

  logic [jcd_pkg::KB-1:0] kn_d, kr_d;
  assign kn_d = top_bit(n1_q);
  assign kr_d = top_bit(r1_q);

  logic                          lv_q [0:LF];
  logic [jcd_pkg::MANT_BITS-1:0] mn_q [0:LF];
  logic [jcd_pkg::MANT_BITS-1:0] mr_q [0:LF];
  logic [jcd_pkg::KB-1:0]        kn_q [0:LF];
  logic [jcd_pkg::KB-1:0]        kr_q [0:LF];
  logic [LF-1:0]                 fn_q [0:LF];
  logic [LF-1:0]                 fr_q [0:LF];
  jcd_pkg::ctl_t                 lc_q [0:LF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q[0] <= 1'b0;
    end else if (en) begin
      lv_q[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mn_q[0] <= jcd_pkg::MANT_BITS'(n1_q) << (jcd_pkg::KB'(31) - kn_d);
      mr_q[0] <= jcd_pkg::MANT_BITS'(r1_q) << (jcd_pkg::KB'(31) - kr_d);
      kn_q[0] <= kn_d;
      kr_q[0] <= kr_d;
      fn_q[0] <= '0;
      fr_q[0] <= '0;
      lc_q[0] <= c1_q;
    end
  end

  // Log stages: each squares the mantissa once and yields one fraction bit.
  for (genvar j = 0; j < LF; j++) begin : g_log
    logic [2*jcd_pkg::MANT_BITS-1:0] sqn, sqr;
    logic [jcd_pkg::MANT_BITS:0]     tn, tr;
    assign sqn = {32'b0, mn_q[j]} * {32'b0, mn_q[j]};
    assign sqr = {32'b0, mr_q[j]} * {32'b0, mr_q[j]};
    assign tn  = sqn[2*jcd_pkg::MANT_BITS-1:31];
    assign tr  = sqr[2*jcd_pkg::MANT_BITS-1:31];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lv_q[j+1] <= 1'b0;
      end else if (en) begin
        lv_q[j+1] <= lv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        mn_q[j+1] <= tn[32] ? tn[32:1] : tn[31:0];
        mr_q[j+1] <= tr[32] ? tr[32:1] : tr[31:0];
        fn_q[j+1] <= fn_q[j] | (LF'(tn[32]) << (LF-1-j));
        fr_q[j+1] <= fr_q[j] | (LF'(tr[32]) << (LF-1-j));
        kn_q[j+1] <= kn_q[j];
        kr_q[j+1] <= kr_q[j];
        lc_q[j+1] <= lc_q[j];
      end
    end
  end

  // Difference of logs, then scaling by ln 2.
  logic [jcd_pkg::LOGB-1:0] ln_full, lr_full;
  assign ln_full = {kn_q[LF], fn_q[LF]};
  assign lr_full = {kr_q[LF], fr_q[LF]};

  logic                     dv_q, pv_q;
  logic                     qv_q [0:NC];
  logic [jcd_pkg::LOGB-1:0] d_q;
  jcd_pkg::ctl_t            dc_q, pc_q;
  logic [jcd_pkg::P_BITS-1:0] p_q;
  logic [jcd_pkg::LOGB+LF-1:0] prod;
  logic [jcd_pkg::P_BITS+4:0]  p19;

  assign prod = {{LF{1'b0}}, d_q} * {{jcd_pkg::LOGB{1'b0}}, jcd_pkg::LN2_Q28};
  assign p19  = {5'b0, p_q} * (jcd_pkg::P_BITS+5)'(19);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q    <= 1'b0;
      pv_q    <= 1'b0;
      qv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q    <= lv_q[LF];
      pv_q    <= dv_q;
      qv_q[0] <= pv_q;
    end
  end

  logic [XB-1:0]      x_d;
  logic [XB-1:0]      xx_q [0:NC];
  logic [XB-1:0]      qd_q [0:NC];
  logic [2:0]         rm_q [0:NC];
  jcd_pkg::ctl_t      qc_q [0:NC];

  always_comb begin
    if (pc_q.mode == jcd_pkg::ALPHA_PROTEIN) begin
      x_d = p19[XB+1:2];
    end else begin
      x_d = XB'({p_q, 1'b0} + {1'b0, p_q}) >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q  <= (ln_full > lr_full) ? (ln_full - lr_full) : '0;
      dc_q <= lc_q[LF];
      p_q  <= prod[jcd_pkg::LOGB+LF-1:20];
      pc_q <= dc_q;
    end
  end

  // The x register is the head of the divide-by-five chain.
  always_ff @(posedge clk_i) begin
    if (en) begin
      xx_q[0] <= x_d;
      qd_q[0] <= '0;
      rm_q[0] <= '0;
      qc_q[0] <= pc_q;
    end
  end

  // Long division by five, one chunk of the quotient per stage.
  for (genvar c = 0; c < NC; c++) begin : g_div
    logic [CW+2:0]  v;
    logic [CW+18:0] mq;
    logic [CW-1:0]  q;
    assign v  = {rm_q[c], xx_q[c][XB-1-c*CW -: CW]};
    assign mq = (CW+19)'(v) * (CW+19)'(jcd_pkg::RECIP5);
    assign q  = mq[CW+15:16];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        qv_q[c+1] <= 1'b0;
      end else if (en) begin
        qv_q[c+1] <= qv_q[c];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        xx_q[c+1] <= xx_q[c];
        qd_q[c+1] <= qd_q[c] | (XB'(q) << (XB-CW-c*CW));
        rm_q[c+1] <= 3'(v - (CW+3)'({q, 2'b00} + q));
        qc_q[c+1] <= qc_q[c];
      end
    end
  end

  // Rounding, range limit and the special cases.
  logic [XB-1:0]   qsel;
  logic [XB:0]     rsum;
  jcd_pkg::out_t   out_d;

  always_comb begin
    qsel = (qc_q[NC].mode == jcd_pkg::ALPHA_PROTEIN) ? qd_q[NC] : xx_q[NC];
    rsum = {1'b0, qsel} + ((XB+1)'(1) << (jcd_pkg::SHIFT-1));
    out_d.saturated = qc_q[NC].sat;
    if (qc_q[NC].zero || qc_q[NC].sat) begin
      out_d.distance = '0;
    end else if (rsum[XB:jcd_pkg::SHIFT+jcd_pkg::DIST_BITS] != '0) begin
      out_d.distance = '1;
    end else begin
      out_d.distance = rsum[jcd_pkg::SHIFT+jcd_pkg::DIST_BITS-1:jcd_pkg::SHIFT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= qv_q[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  `JCD_ASSERT(a_sat_zero_dist, out_valid_o && out_data_o.saturated |-> out_data_o.distance == '0)
  `JCD_ASSERT(a_zero_not_sat, v1_q |-> !(c1_q.zero && c1_q.sat))
  `JCD_ASSERT(a_rem_range, qv_q[NC] |-> rm_q[NC] < 3'd5)
  `JCD_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o)

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the Jukes-Cantor distance correction pipeline.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_CYCLES = 38;
  localparam int SETTLE      = PIPE_CYCLES + 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [jcd_pkg::COUNT_BITS-1:0] CMAX = '1;

  typedef struct {
    logic [jcd_pkg::COUNT_BITS-1:0] first;
    logic [jcd_pkg::COUNT_BITS-1:0] second;
    logic [jcd_pkg::COUNT_BITS-1:0] sites;
    bit                             known;
    logic [jcd_pkg::DIST_BITS-1:0]  exp_dist;
    logic                           sat;
  } pair_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic            cfg_wdata_i = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  jcd_pkg::in_t    in_data_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  jcd_pkg::out_t   out_data_o;

  jcd_pkg::alpha_e alphabet = jcd_pkg::ALPHA_DNA;
  jcd_pkg::out_t   pending_distances[$];
  int              errors = 0;
  int              cycles = 0;
  bit              idling_on = 1'b1;
  int              stall_left = 0;

  jukes_cantor_distance uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Fixed-point log2 with 28 fraction bits, mantissa kept in Q1.31.
  function automatic logic [63:0] log2_q28(logic [63:0] x);
    int          k;
    logic [63:0] m;
    logic [63:0] res;
    if (x == 0) return 64'd0;
    k = 0;
    while (k < 63 && (x >> (k + 1)) != 0) k++;
    m = (k >= 31) ? (x >> (k - 31)) : (x << (31 - k));
    res = 64'(k) << jcd_pkg::LOG_FRAC;
    for (int i = jcd_pkg::LOG_FRAC - 1; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic jcd_pkg::out_t jc_distance(jcd_pkg::in_t it, jcd_pkg::alpha_e md);
    logic [63:0]   alpha, total, n, aa, r, ln_n, ln_r, d, p, q, dist_val;
    jcd_pkg::out_t res;
    res = '0;
    alpha = (md == jcd_pkg::ALPHA_PROTEIN) ? 64'd20 : 64'd4;
    total = 64'(it.mismatch_count_first) + 64'(it.mismatch_count_second);
    if (it.compared_sites == 0) return res;
    n = (alpha - 1) * 64'(it.compared_sites);
    aa = alpha * total;
    if (aa >= n) begin
      res.saturated = 1'b1;
      return res;
    end
    r = n - aa;
    ln_n = log2_q28(n);
    ln_r = log2_q28(r);
    d = (ln_n > ln_r) ? (ln_n - ln_r) : 64'd0;
    p = (d * 64'(jcd_pkg::LN2_Q28)) >> 20;
    q = (p * (alpha - 1)) / alpha;
    dist_val = (q + (64'd1 << (jcd_pkg::SHIFT - 1))) >> jcd_pkg::SHIFT;
    if (dist_val > 64'((1 << jcd_pkg::DIST_BITS) - 1))
      dist_val = 64'((1 << jcd_pkg::DIST_BITS) - 1);
    res.distance = dist_val[jcd_pkg::DIST_BITS-1:0];
    return res;
  endfunction

  task automatic send_pair(jcd_pkg::in_t it, bit known, jcd_pkg::out_t want);
    jcd_pkg::out_t exp_res;
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    exp_res = known ? want : jc_distance(it, alphabet);
    pending_distances.push_back(exp_res);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic drain_and_set(jcd_pkg::alpha_e md);
    in_valid_i <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= md;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    alphabet = md;
  endtask

  function automatic jcd_pkg::in_t random_pair(jcd_pkg::alpha_e md);
    jcd_pkg::in_t it;
    logic [63:0]  alpha, tmax, total;
    alpha = (md == jcd_pkg::ALPHA_PROTEIN) ? 64'd20 : 64'd4;
    if ($urandom_range(0, 4) == 0) begin
      it.mismatch_count_first  = jcd_pkg::COUNT_BITS'($urandom);
      it.mismatch_count_second = jcd_pkg::COUNT_BITS'($urandom);
      it.compared_sites        = ($urandom_range(0, 9) == 0) ? '0 :
                                 jcd_pkg::COUNT_BITS'($urandom);
    end else begin
      it.compared_sites = $urandom_range(0, 1) ?
                          jcd_pkg::COUNT_BITS'($urandom_range(1, 64)) :
                          jcd_pkg::COUNT_BITS'($urandom_range(1, 1048575));
      tmax = ((alpha - 1) * 64'(it.compared_sites) - 1) / alpha;
      // Roughly one valid pair in four lands close to the saturation limit to stress the log units.
      if ($urandom_range(0, 3) == 0 && tmax > 8)
        total = tmax - 64'($urandom_range(0, 8));
      else
        total = 64'($urandom_range(0, 32'(tmax)));
      it.mismatch_count_first  = jcd_pkg::COUNT_BITS'($urandom_range(0, 32'(total)));
      it.mismatch_count_second = jcd_pkg::COUNT_BITS'(total) - it.mismatch_count_first;
    end
    return it;
  endfunction

  // Receiver stalls come in bursts.
  always @(posedge clk_i) begin
    if (!idling_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left  <= $urandom_range(0, 17);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    jcd_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_distances.size() == 0) begin
        $error("unexpected result transfer: distance %0d saturated %0b",
               out_data_o.distance, out_data_o.saturated);
        errors++;
      end else begin
        want = pending_distances.pop_front();
        if (out_data_o.distance !== want.distance) begin
          $error("distance: expected %0d, actual %0d", want.distance, out_data_o.distance);
          errors++;
        end
        if (out_data_o.saturated !== want.saturated) begin
          $error("saturated: expected %0b, actual %0b", want.saturated, out_data_o.saturated);
          errors++;
        end
      end
    end
  end

  initial begin
    pair_row_t       rows[$];
    jcd_pkg::in_t    it;
    jcd_pkg::out_t   want;
    jcd_pkg::alpha_e plan[5];
    int              waited;

    rows = '{
      '{'0, '0, '0, 1, '0, 1'b0},
      '{CMAX, CMAX, '0, 1, '0, 1'b0},
      '{'0, '0, CMAX, 1, '0, 1'b0},
      '{'0, '0, 20'd1, 1, '0, 1'b0},
      '{CMAX, CMAX, CMAX, 1, '0, 1'b1},
      '{CMAX, '0, 20'd1, 1, '0, 1'b1},
      '{20'd1, '0, 20'd1, 1, '0, 1'b1},
      '{'0, 20'd1, 20'd1, 1, '0, 1'b1},
      '{20'd375, 20'd375, 20'd1000, 0, '0, 1'b0},
      '{20'hAAAAA, 20'h55555, 20'h55555, 1, '0, 1'b1},
      '{20'd374, 20'd375, 20'd1000, 0, '0, 1'b0},
      '{20'd1, '0, 20'd4, 0, '0, 1'b0},
      '{'0, 20'd1, 20'd100, 0, '0, 1'b0},
      '{20'd100, 20'd200, 20'd1000, 0, '0, 1'b0},
      '{20'd1, 20'd1, CMAX, 0, '0, 1'b0},
      '{20'h3FFFF, '0, CMAX, 0, '0, 1'b0},
      '{20'h0AAAA, 20'h05555, 20'hAAAAA, 0, '0, 1'b0},
      '{20'd393215, 20'd393215, CMAX, 0, '0, 1'b0},
      '{20'd2, '0, 20'd4, 0, '0, 1'b0}
    };
    plan = '{jcd_pkg::ALPHA_PROTEIN, jcd_pkg::ALPHA_DNA, jcd_pkg::ALPHA_PROTEIN,
             jcd_pkg::ALPHA_DNA, jcd_pkg::ALPHA_PROTEIN};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows run with the reset alphabet, then with the protein alphabet.
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) drain_and_set(jcd_pkg::ALPHA_PROTEIN);
      foreach (rows[i]) begin
        it.mismatch_count_first  = rows[i].first;
        it.mismatch_count_second = rows[i].second;
        it.compared_sites        = rows[i].sites;
        want.distance  = rows[i].exp_dist;
        want.saturated = rows[i].sat;
        send_pair(it, rows[i].known, want);
      end
    end

    for (int ph = 0; ph < 5; ph++) begin
      drain_and_set(plan[ph]);
      if (ph == 4) idling_on = 1'b0;
      for (int n = 0; n < 270; n++) begin
        it = random_pair(alphabet);
        send_pair(it, 1'b0, want);
      end
    end

    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_distances.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0 && pending_distances.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/jcd_pkg.sv
src/jukes_cantor_distance.sv
dv/tb_top.sv
